/* design/pixel_unpremultiply_frame_stats_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pixel unpremultiply and frame statistics block
// Shorthand for the clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_UNPREMULTIPLY_FRAME_STATS_ASSERT_SVH
`define PIXEL_UNPREMULTIPLY_FRAME_STATS_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define UPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/upf_pkg.sv */
// ----------------------------------------------------------------------------
// upf_pkg
// Shared types and constants of the pixel unpremultiply and frame statistics
// block.
// ----------------------------------------------------------------------------
package upf_pkg;

  // Fixed point format of the pixel fields.
  localparam int FRAC_BITS = 12;
  localparam int ONE_W = FRAC_BITS + 1;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int IN_W = 16;
  localparam int NCH = 3;

  // Thresholds in Q.12 units.
  localparam int EDGE_LIMIT = ONE / 100;
  localparam int OPAQUE_LIMIT = ONE / 255;

  // Frame geometry.
  localparam int MAX_DIM = 4096;
  localparam int MIN_DIM = 3;
  localparam int CFG_DIM_W = 13;

  // Accumulator widths.
  localparam int ACT_W = 37;
  localparam int CNT_W = 25;

  // Queue of classified pixels between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCENE_MODE = 2'd2;

  localparam logic [CFG_DIM_W-1:0] RESET_DIM = 13'd512;

  typedef struct packed {
    logic signed [IN_W-1:0] pix_red;
    logic signed [IN_W-1:0] pix_green;
    logic signed [IN_W-1:0] pix_blue;
    logic signed [IN_W-1:0] pix_alpha;
    logic signed [IN_W-1:0] bg_red;
    logic signed [IN_W-1:0] bg_green;
    logic signed [IN_W-1:0] bg_blue;
  } pixel_t;

  typedef struct packed {
    logic [ONE_W-1:0] out_red;
    logic [ONE_W-1:0] out_green;
    logic [ONE_W-1:0] out_blue;
    logic [ONE_W-1:0] out_alpha;
    logic             frame_done;
    logic [ONE_W-1:0] peak_rgb;
    logic [ACT_W-1:0] activity_total;
    logic [CNT_W-1:0] edge_hits;
    logic [CNT_W-1:0] opaque_hits;
  } result_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    logic                 scene_mode;
  } cfg_t;

  // Classified pixel handed from front to back. A channel either has its
  // final value in fixed, or needs num * ONE / alpha with num < alpha.
  typedef struct packed {
    logic [NCH-1:0][ONE_W-1:0]     fixed;
    logic [NCH-1:0][FRAC_BITS-1:0] num;
    logic [NCH-1:0]                div;
    logic [ONE_W-1:0]              alpha;
    logic [ONE_W-1:0]              diff;
    logic                          edge_hit;
    logic                          opaque_hit;
    logic                          last;
  } item_t;

endpackage

/* design/pixel_unpremultiply_frame_stats.sv */
// ----------------------------------------------------------------------------
// pixel_unpremultiply_frame_stats
// Alpha recovery and unpremultiply of raster pixels with per-frame totals.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                        Direction  Moves
//   pixel     pix_valid, pix_stall, pix      in         one pixel item
//   result    res_valid, res_stall, res      out        one result item
//   config    psel, penable, pwrite, paddr,  in/out     register write/read
//             pwdata, prdata, pready
//
// An item whose channels all have a fixed answer (scene mode, zero or
// negative color, color at or above alpha) is written to the result as it
// is taken from the queue. An item with at least one channel to divide is
// first taken from the queue, then divided one quotient bit per step, and
// then its result is written. Three restoring-division lanes produce one quotient bit per cycle each.
// The front end accepts a pixel in any cycle in which the two-entry queue
// has room, so a burst of pixels is absorbed while the divider is busy.
// Reset is synchronous and clears position, totals, queue and result valid;
// the block needs no clearing pass. A stalled result holds its register
// and the back end waits; the pixel side stalls only once the queue is full.
//
// Per pixel: in scene mode alpha is forced to one and the color clamped.
// Otherwise alpha is the larger of the clamped opacity and the clamped peak
// color channel, and each channel is divided by that alpha and saturated at
// one. Frame totals (peak channel, sum of background differences, changed
// pixels near the border, non-transparent pixels) are reported on the
// frame's last pixel and cleared at the same time.
// ----------------------------------------------------------------------------
module pixel_unpremultiply_frame_stats #(
  parameter int MAX_DIM = upf_pkg::MAX_DIM
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pix_valid,
  output logic                         pix_stall,
  input  upf_pkg::pixel_t              pix,
  output logic                         res_valid,
  input  logic                         res_stall,
  output upf_pkg::result_t             res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [upf_pkg::ADDR_W-1:0]   paddr,
  input  logic [upf_pkg::DATA_W-1:0]   pwdata,
  output logic [upf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  upf_pkg::cfg_t                    cfg;
  logic [upf_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                             cfg_write;

  logic            q_full;
  logic            q_push;
  upf_pkg::item_t  q_push_item;
  logic            q_pop;
  upf_pkg::item_t  q_pop_item;
  logic            q_valid;

  // Configuration registers. Registers sit on word addresses; the low two
  // address bits are ignored.
  assign pready = 1'b1;
  assign reg_idx = paddr[upf_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width <= upf_pkg::RESET_DIM;
      cfg.frame_height <= upf_pkg::RESET_DIM;
      cfg.scene_mode <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        upf_pkg::REG_FRAME_WIDTH: begin
          cfg.frame_width <= pwdata[upf_pkg::CFG_DIM_W-1:0];
        end
        upf_pkg::REG_FRAME_HEIGHT: begin
          cfg.frame_height <= pwdata[upf_pkg::CFG_DIM_W-1:0];
        end
        upf_pkg::REG_SCENE_MODE: begin
          cfg.scene_mode <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      upf_pkg::REG_FRAME_WIDTH: begin
        prdata = upf_pkg::DATA_W'(cfg.frame_width);
      end
      upf_pkg::REG_FRAME_HEIGHT: begin
        prdata = upf_pkg::DATA_W'(cfg.frame_height);
      end
      upf_pkg::REG_SCENE_MODE: begin
        prdata = upf_pkg::DATA_W'(cfg.scene_mode);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // The pixel side stalls only when the queue to the back end is full.
  assign pix_stall = q_full;

  upf_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix       (pix),
    .cfg       (cfg),
    .full      (q_full),
    .push      (q_push),
    .item      (q_push_item)
  );

  upf_queue #(
    .DEPTH (upf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .not_empty (q_valid)
  );

  upf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_pop_item),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

/* design/upf_queue.sv */
// ----------------------------------------------------------------------------
// upf_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module upf_queue #(
  parameter int DEPTH = upf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  upf_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output upf_pkg::item_t pop_item,
  output logic           not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  upf_pkg::item_t    slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full = (fill == FILL_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_item;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* design/upf_front.sv */
// ----------------------------------------------------------------------------
// upf_front
// Accepts pixels, tracks the raster position and classifies each pixel.
// ----------------------------------------------------------------------------
module upf_front #(
  parameter int MAX_DIM = upf_pkg::MAX_DIM
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  input  upf_pkg::pixel_t pix,
  input  upf_pkg::cfg_t   cfg,
  input  logic            full,
  output logic            push,
  output upf_pkg::item_t  item
);

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int DIM_W = (POS_W + 1 > upf_pkg::CFG_DIM_W) ? POS_W + 1 : upf_pkg::CFG_DIM_W;
  localparam int ONE_W = upf_pkg::ONE_W;
  localparam int FB = upf_pkg::FRAC_BITS;
  localparam int DW = upf_pkg::IN_W + 1;

  logic [POS_W-1:0] col;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col_next;
  logic [POS_W-1:0] row_next;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [DIM_W-1:0] col_ext;
  logic [DIM_W-1:0] row_ext;
  logic             end_row;
  logic             near_border;

  logic signed [upf_pkg::IN_W-1:0] chan [upf_pkg::NCH];
  logic signed [upf_pkg::IN_W-1:0] bgc  [upf_pkg::NCH];
  logic [DW-1:0]                   adiff [upf_pkg::NCH];
  logic [DW-1:0]                   dmax;
  logic signed [upf_pkg::IN_W-1:0] cmax;
  logic [ONE_W-1:0]                op;
  logic [ONE_W-1:0]                em;
  logic [ONE_W-1:0]                oa;

  function automatic logic [ONE_W-1:0] clamp_s(input logic signed [upf_pkg::IN_W-1:0] v);
    logic [ONE_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > upf_pkg::IN_W'(upf_pkg::ONE)) begin
      r = ONE_W'(upf_pkg::ONE);
    end else begin
      r = v[ONE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] sat_dim(input logic [upf_pkg::CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] e;
    logic [DIM_W-1:0] r;
    e = DIM_W'(v);
    if (e < DIM_W'(upf_pkg::MIN_DIM)) begin
      r = DIM_W'(upf_pkg::MIN_DIM);
    end else if (e > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = e;
    end
    return r;
  endfunction

  always_comb begin
    push = pix_valid && !full;

    w = sat_dim(cfg.frame_width);
    h = sat_dim(cfg.frame_height);
    col_ext = DIM_W'(col);
    row_ext = DIM_W'(row);
    end_row = (col_ext >= w - 1'b1);
    item.last = end_row && (row_ext >= h - 1'b1);
    near_border = (col_ext < DIM_W'(2)) || (row_ext < DIM_W'(2)) ||
                  (col_ext >= w - DIM_W'(2)) || (row_ext >= h - DIM_W'(2));

    chan[0] = pix.pix_red;
    chan[1] = pix.pix_green;
    chan[2] = pix.pix_blue;
    bgc[0] = cfg.scene_mode ? pix.bg_red : '0;
    bgc[1] = cfg.scene_mode ? pix.bg_green : '0;
    bgc[2] = cfg.scene_mode ? pix.bg_blue : '0;

    // Largest absolute background difference, clamped to one.
    dmax = '0;
    for (int k = 0; k < upf_pkg::NCH; k++) begin
      adiff[k] = DW'({chan[k][upf_pkg::IN_W-1], chan[k]}) -
                 DW'({bgc[k][upf_pkg::IN_W-1], bgc[k]});
      if (adiff[k][DW-1]) begin
        adiff[k] = -adiff[k];
      end
      if (adiff[k] > dmax) begin
        dmax = adiff[k];
      end
    end
    item.diff = (dmax > DW'(upf_pkg::ONE)) ? ONE_W'(upf_pkg::ONE) : dmax[ONE_W-1:0];
    item.edge_hit = (item.diff > ONE_W'(upf_pkg::EDGE_LIMIT)) && near_border;

    // Recovered alpha: larger of opacity and peak color channel.
    cmax = chan[0];
    if (chan[1] > cmax) begin
      cmax = chan[1];
    end
    if (chan[2] > cmax) begin
      cmax = chan[2];
    end
    op = clamp_s(pix.pix_alpha);
    em = clamp_s(cmax);
    oa = (op > em) ? op : em;

    item.alpha = cfg.scene_mode ? ONE_W'(upf_pkg::ONE) : oa;
    item.opaque_hit = cfg.scene_mode || (oa > ONE_W'(upf_pkg::OPAQUE_LIMIT));

    for (int k = 0; k < upf_pkg::NCH; k++) begin
      item.fixed[k] = '0;
      item.num[k] = chan[k][FB-1:0];
      item.div[k] = 1'b0;
      if (cfg.scene_mode) begin
        item.fixed[k] = clamp_s(chan[k]);
      end else if (chan[k] > 0 && oa != '0) begin
        if (chan[k] >= $signed({{(upf_pkg::IN_W - ONE_W){1'b0}}, oa})) begin
          item.fixed[k] = ONE_W'(upf_pkg::ONE);
        end else begin
          item.div[k] = 1'b1;
        end
      end
    end

    col_next = col;
    row_next = row;
    if (push) begin
      if (item.last) begin
        col_next = '0;
        row_next = '0;
      end else if (end_row) begin
        col_next = '0;
        row_next = row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

/* design/upf_back.sv */
// ----------------------------------------------------------------------------
// upf_back
// Divides the color channels, updates the frame totals and holds the result.
// ----------------------------------------------------------------------------
module upf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  upf_pkg::item_t   q_item,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output upf_pkg::result_t res
);

  localparam int FB = upf_pkg::FRAC_BITS;
  localparam int ONE_W = upf_pkg::ONE_W;
  localparam int NCH = upf_pkg::NCH;
  localparam int ACT_W = upf_pkg::ACT_W;
  localparam int CNT_W = upf_pkg::CNT_W;
  localparam int STEP_W = $clog2(FB + 1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t          state;
  upf_pkg::item_t  cur;
  logic [NCH-1:0][FB-1:0] rem;
  logic [NCH-1:0][FB-1:0] quo;
  logic [STEP_W-1:0]      step;

  logic [ONE_W-1:0] peak_acc;
  logic [ACT_W-1:0] activity_acc;
  logic [CNT_W-1:0] edge_acc;
  logic [CNT_W-1:0] opaque_acc;

  logic                    out_free;
  logic                    q_div;
  logic                    done;
  upf_pkg::item_t          fin_item;
  logic [NCH-1:0][ONE_W-1:0] fin_ch;
  logic [NCH-1:0][FB-1:0]  rem_next;
  logic [NCH-1:0][FB-1:0]  quo_next;
  logic [ONE_W-1:0]        trial [NCH];
  logic [ONE_W-1:0]        pk;
  logic [ONE_W-1:0]        peak_next;
  logic [ACT_W:0]          act_sum;
  logic [ACT_W-1:0]        activity_next;
  logic [CNT_W-1:0]        edge_next;
  logic [CNT_W-1:0]        opaque_next;
  upf_pkg::result_t        res_next;

  always_comb begin
    out_free = !res_valid || !res_stall;
    q_div = |q_item.div;
    pop = (state == ST_IDLE) && q_valid && (q_div || out_free);
    done = ((state == ST_IDLE) && q_valid && !q_div && out_free) ||
           ((state == ST_DIV) && (step == '0) && out_free);
    fin_item = (state == ST_DIV) ? cur : q_item;

    // One restoring division step per lane and cycle.
    for (int k = 0; k < NCH; k++) begin
      trial[k] = {rem[k], 1'b0};
      if (trial[k] >= cur.alpha) begin
        rem_next[k] = FB'(trial[k] - cur.alpha);
        quo_next[k] = {quo[k][FB-2:0], 1'b1};
      end else begin
        rem_next[k] = trial[k][FB-1:0];
        quo_next[k] = {quo[k][FB-2:0], 1'b0};
      end
      fin_ch[k] = fin_item.div[k] ? {1'b0, quo[k]} : fin_item.fixed[k];
    end

    pk = fin_ch[0];
    if (fin_ch[1] > pk) begin
      pk = fin_ch[1];
    end
    if (fin_ch[2] > pk) begin
      pk = fin_ch[2];
    end
    peak_next = (pk > peak_acc) ? pk : peak_acc;

    act_sum = {1'b0, activity_acc} + (ACT_W + 1)'(fin_item.diff);
    activity_next = act_sum[ACT_W] ? '1 : act_sum[ACT_W-1:0];
    edge_next = (fin_item.edge_hit && edge_acc != '1) ? edge_acc + 1'b1 : edge_acc;
    opaque_next = (fin_item.opaque_hit && opaque_acc != '1) ? opaque_acc + 1'b1 : opaque_acc;

    res_next.out_red = fin_ch[0];
    res_next.out_green = fin_ch[1];
    res_next.out_blue = fin_ch[2];
    res_next.out_alpha = fin_item.alpha;
    res_next.frame_done = fin_item.last;
    res_next.peak_rgb = fin_item.last ? peak_next : '0;
    res_next.activity_total = fin_item.last ? activity_next : '0;
    res_next.edge_hits = fin_item.last ? edge_next : '0;
    res_next.opaque_hits = fin_item.last ? opaque_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      res_valid <= 1'b0;
      peak_acc <= '0;
      activity_acc <= '0;
      edge_acc <= '0;
      opaque_acc <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop && q_div) begin
            cur <= q_item;
            rem <= q_item.num;
            quo <= '0;
            step <= STEP_W'(FB);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step != '0) begin
            rem <= rem_next;
            quo <= quo_next;
            step <= step - 1'b1;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (done) begin
        res_valid <= 1'b1;
        res <= res_next;
        if (fin_item.last) begin
          peak_acc <= '0;
          activity_acc <= '0;
          edge_acc <= '0;
          opaque_acc <= '0;
        end else begin
          peak_acc <= peak_next;
          activity_acc <= activity_next;
          edge_acc <= edge_next;
          opaque_acc <= opaque_next;
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/upf_checker.sv */
// ----------------------------------------------------------------------------
// upf_checker
// Port-level checks of the result channel, attached to the top level.
// ----------------------------------------------------------------------------
`include "pixel_unpremultiply_frame_stats_assert.svh"

module upf_checker (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_stall,
  input upf_pkg::result_t res
);

  // A stalled result stays offered and unchanged.
  `UPF_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

  // Reset withdraws any pending result.
  `UPF_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, !res_valid, "result valid after reset")

  // Frame totals are shown only on the frame's last pixel.
  `UPF_ASSERT_NOW(a_totals_only_at_end, clk, rst, res_valid && !res.frame_done, res.peak_rgb == '0 && res.activity_total == '0 && res.edge_hits == '0 && res.opaque_hits == '0, "totals outside frame end")

endmodule

bind pixel_unpremultiply_frame_stats upf_checker u_upf_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

/* tb/tb_pixel_unpremultiply_frame_stats.sv */
// ----------------------------------------------------------------------------
// Testbench for the pixel unpremultiply and frame statistics block
// Streams raster pixels through the block under a series of frame sizes and
// both alpha modes, predicts every result item from a behavioral copy of the
// block, and compares each accepted result field by field. Both handshake
// sides idle at random, and the register port is exercised between phases.
// ----------------------------------------------------------------------------
module tb_pixel_unpremultiply_frame_stats;
  timeunit 1ns;
  timeprecision 1ps;

  import upf_pkg::*;

  // Generous bound: even with every pixel needing the divider and the longest
  // source gaps and sink stalls, the run stays far below this.
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS = 110;
  localparam int N_PHASES = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 40;

  // --------------------------------------------------------------------------
  // Behavioral copy of the block. It keeps its own registers, raster position
  // and running frame totals, and queues one expected result per pixel.
  // --------------------------------------------------------------------------
  class frame_stats_tracker;
    cfg_t regs;
    int unsigned col_pos;
    int unsigned row_pos;
    longint unsigned peak_run;
    longint unsigned activity_run;
    longint unsigned edge_run;
    longint unsigned opaque_run;
    result_t expected_q[$];
    int unsigned mismatches;
    int unsigned pixels_seen;
    int unsigned results_seen;
    int unsigned frames_seen;

    function new();
      regs.frame_width = RESET_DIM;
      regs.frame_height = RESET_DIM;
      regs.scene_mode = 1'b0;
      col_pos = 0;
      row_pos = 0;
      peak_run = 0;
      activity_run = 0;
      edge_run = 0;
      opaque_run = 0;
      mismatches = 0;
      pixels_seen = 0;
      results_seen = 0;
      frames_seen = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_FRAME_WIDTH: regs.frame_width = value[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: regs.frame_height = value[CFG_DIM_W-1:0];
        REG_SCENE_MODE: regs.scene_mode = value[0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_FRAME_WIDTH: return DATA_W'(regs.frame_width);
        REG_FRAME_HEIGHT: return DATA_W'(regs.frame_height);
        REG_SCENE_MODE: return DATA_W'(regs.scene_mode);
        default: return '0;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function longint unit_clip(longint v);
      if (v < 0) return 0;
      if (v > ONE) return ONE;
      return v;
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint largest(longint a, longint b, longint c);
      longint m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
    endfunction

    function int unsigned dim_of(logic [CFG_DIM_W-1:0] r);
      if (r < MIN_DIM) return MIN_DIM;
      if (r > MAX_DIM) return MAX_DIM;
      return r;
    endfunction

    // Floor of c / a in Q.12, zero for a non-positive channel, capped at one.
    function longint unpremultiplied(longint c, longint a);
      longint q;
      if (c <= 0) return 0;
      q = (c * ONE) / a;
      return (q > ONE) ? ONE : q;
    endfunction

    function void note_pixel(pixel_t p);
      longint r, g, b, a, br, bgg, bb;
      longint diff, op, em, oa, col_r, col_g, col_b, pk;
      longint unsigned act_max, cnt_max;
      int unsigned w, h;
      bit opaque, end_row;
      result_t e;
      act_max = (64'd1 << ACT_W) - 1;
      cnt_max = (64'd1 << CNT_W) - 1;
      r = $signed(p.pix_red);
      g = $signed(p.pix_green);
      b = $signed(p.pix_blue);
      a = $signed(p.pix_alpha);
      br = 0;
      bgg = 0;
      bb = 0;
      if (regs.scene_mode) begin
        br = $signed(p.bg_red);
        bgg = $signed(p.bg_green);
        bb = $signed(p.bg_blue);
      end
      w = dim_of(regs.frame_width);
      h = dim_of(regs.frame_height);
      pixels_seen++;

      diff = unit_clip(largest(magnitude(r - br), magnitude(g - bgg), magnitude(b - bb)));
      activity_run += diff;
      if (activity_run > act_max) activity_run = act_max;
      if (diff > EDGE_LIMIT &&
          (col_pos < 2 || row_pos < 2 || col_pos >= w - 2 || row_pos >= h - 2)) begin
        if (edge_run < cnt_max) edge_run++;
      end

      if (regs.scene_mode) begin
        col_r = unit_clip(r);
        col_g = unit_clip(g);
        col_b = unit_clip(b);
        oa = ONE;
        opaque = 1'b1;
      end else begin
        op = unit_clip(a);
        em = unit_clip(largest(r, g, b));
        oa = (op > em) ? op : em;
        if (oa > 0) begin
          col_r = unpremultiplied(r, oa);
          col_g = unpremultiplied(g, oa);
          col_b = unpremultiplied(b, oa);
        end else begin
          col_r = 0;
          col_g = 0;
          col_b = 0;
        end
        opaque = oa > OPAQUE_LIMIT;
      end
      if (opaque && opaque_run < cnt_max) opaque_run++;
      pk = largest(col_r, col_g, col_b);
      if (pk > peak_run) peak_run = pk;

      e = '0;
      e.out_red = ONE_W'(col_r);
      e.out_green = ONE_W'(col_g);
      e.out_blue = ONE_W'(col_b);
      e.out_alpha = ONE_W'(oa);
      end_row = col_pos >= w - 1;
      if (end_row && row_pos >= h - 1) begin
        e.frame_done = 1'b1;
        e.peak_rgb = ONE_W'(peak_run);
        e.activity_total = ACT_W'(activity_run);
        e.edge_hits = CNT_W'(edge_run);
        e.opaque_hits = CNT_W'(opaque_run);
        peak_run = 0;
        activity_run = 0;
        edge_run = 0;
        opaque_run = 0;
        col_pos = 0;
        row_pos = 0;
      end else if (end_row) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                  results_seen, name, got, want));
      end
    endtask

    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected: %h",
                                  results_seen, got));
        return;
      end
      want = expected_q.pop_front();
      if (want.frame_done) frames_seen++;
      compare_field("out_red", got.out_red, want.out_red);
      compare_field("out_green", got.out_green, want.out_green);
      compare_field("out_blue", got.out_blue, want.out_blue);
      compare_field("out_alpha", got.out_alpha, want.out_alpha);
      compare_field("frame_done", got.frame_done, want.frame_done);
      compare_field("peak_rgb", got.peak_rgb, want.peak_rgb);
      compare_field("activity_total", got.activity_total, want.activity_total);
      compare_field("edge_hits", got.edge_hits, want.edge_hits);
      compare_field("opaque_hits", got.opaque_hits, want.opaque_hits);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts at a known value.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  pixel_t pix = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  result_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  frame_stats_tracker tracker;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned settings_used = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_unpremultiply_frame_stats u_top (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix      (pix),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Both handshakes are observed in one process at the rising edge, so the
  // pixel accepted at an edge is always predicted before a result taken at
  // that same edge is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && !pix_stall) tracker.note_pixel(pix);
      if (res_valid && !res_stall) tracker.check_result(res);
    end
  end

  // The result side holds off in random bursts. The rate is set per
  // phase; a rate of zero gives long stretches with the sink always ready.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      res_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!rst && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      res_stall <= 1'b1;
      stall_left = $urandom_range(4);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("run stopped after %0d cycles with %0d results still outstanding",
               cycle_count, tracker.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task is entered and left just after a falling edge.
  // --------------------------------------------------------------------------

  // Register write: a setup cycle, then an access cycle held until pready.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Register read back, compared with the value the tracker holds.
  task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] want;
    want = tracker.reg_value(idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      tracker.report_mismatch($sformatf("register %0d read %0h, expected %0h",
                                        idx, prdata, want));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // One pixel item, optionally preceded by a random source gap.
  // Valid stays high across back-to-back items.
  task automatic send_pixel(input pixel_t p);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (pix_stall);
    @(negedge clk);
  endtask

  // Holds the source off until every predicted result has come back.
  task automatic drain_results();
    pix_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only with the block drained; the raster position and
  // the running totals carry over, so most changes land mid-frame.
  task automatic apply_settings(input int w, input int h, input bit scene);
    drain_results();
    reg_write(REG_FRAME_WIDTH, DATA_W'(w));
    reg_write(REG_FRAME_HEIGHT, DATA_W'(h));
    reg_write(REG_SCENE_MODE, DATA_W'(scene));
    reg_check(REG_FRAME_WIDTH);
    reg_check(REG_FRAME_HEIGHT);
    reg_check(REG_SCENE_MODE);
    settings_used++;
  endtask

  function automatic pixel_t make_pixel(input int r, input int g, input int b, input int a,
                                        input int br, input int bgg, input int bb);
    pixel_t p;
    p.pix_red = IN_W'(r);
    p.pix_green = IN_W'(g);
    p.pix_blue = IN_W'(b);
    p.pix_alpha = IN_W'(a);
    p.bg_red = IN_W'(br);
    p.bg_green = IN_W'(bgg);
    p.bg_blue = IN_W'(bb);
    return p;
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Random pixels: half are premultiplied content (color mostly at or
  // below alpha), plus raw noise, negative and transparent pixels, values
  // around the opacity and change thresholds, and overbright pixels.
  function automatic pixel_t random_pixel();
    int kind, a, r, g, b;
    pixel_t p;
    kind = $urandom_range(9);
    case (kind)
      0: begin
        p = make_pixel($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      1: begin
        p = make_pixel(span(-ONE, 0), span(-ONE, 0), span(-ONE, 0), span(-ONE, 0),
                       span(-ONE, ONE), span(-ONE, ONE), span(-ONE, ONE));
      end
      7, 8: begin
        r = span(-60, 60);
        g = span(-60, 60);
        b = span(-60, 60);
        p = make_pixel(r, g, b, span(-4, 45), r + span(-60, 60), g + span(-60, 60),
                       b + span(-60, 60));
      end
      9: begin
        p = make_pixel(span(ONE - 200, ONE + 200), span(ONE - 200, ONE + 200),
                       span(ONE - 200, ONE + 200), span(ONE - 200, ONE + 200),
                       span(-ONE / 4, ONE), span(-ONE / 4, ONE), span(-ONE / 4, ONE));
      end
      default: begin
        a = span(0, ONE);
        r = span(-ONE / 16, a);
        g = span(-ONE / 16, a);
        b = span(-ONE / 16, a + ONE / 16);
        if ($urandom_range(1)) begin
          p = make_pixel(r, g, b, a, r + span(-200, 200), g + span(-200, 200),
                         b + span(-200, 200));
        end else begin
          p = make_pixel(r, g, b, a, span(-ONE / 4, ONE + ONE / 4),
                         span(-ONE / 4, ONE + ONE / 4), span(-ONE / 4, ONE + ONE / 4));
        end
      end
    endcase
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int w, h, i;
    bit scene;
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part in unpremultiply mode on the smallest legal frame, so
    // that two whole 3 by 3 frames complete and report their totals. The
    // background fields carry junk here; this mode must ignore them.
    apply_settings(3, 3, 1'b0);
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0));                      // fully transparent
    send_pixel(make_pixel(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
    send_pixel(make_pixel(32767, 32767, 32767, 32767, -32768, -32768, -32768));
    send_pixel(make_pixel(2048, 1024, 0, ONE, 1234, -99, 7));         // alpha of one
    send_pixel(make_pixel(1000, 500, -5, 2000, 0, 0, 0));             // real divisions
    send_pixel(make_pixel(3000, 0, 0, 0, 0, 0, 0));                   // alpha from color
    send_pixel(make_pixel(0, 0, 0, OPAQUE_LIMIT, 0, 0, 0));           // just transparent
    send_pixel(make_pixel(0, 0, 0, OPAQUE_LIMIT + 1, 0, 0, 0));       // just opaque
    send_pixel(make_pixel(EDGE_LIMIT, 0, 0, ONE, 0, 0, 0));           // not a change
    send_pixel(make_pixel(EDGE_LIMIT + 1, 0, 0, ONE, 0, 0, 0));       // smallest change
    send_pixel(make_pixel(ONE + 1, 0, 0, 100, 0, 0, 0));              // overbright color
    send_pixel(make_pixel(-1, ONE, 1, -1, 0, 0, 0));
    send_pixel(make_pixel(1, 2, 3, ONE, 0, 0, 0));                    // tiny quotients
    send_pixel(make_pixel(ONE - 1, ONE - 2, ONE - 3, ONE, 0, 0, 0));
    send_pixel(make_pixel(7, 5, 3, 9, 0, 0, 0));                      // small alpha
    send_pixel(make_pixel(2047, 2048, 2049, 2048, 0, 0, 0));          // color above alpha
    send_pixel(make_pixel(-32768, 32767, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(ONE, ONE, ONE, ONE, 0, 0, 0));

    // Directed part in scene mode: background differences at both extremes,
    // at zero and around the change threshold.
    apply_settings(3, 3, 1'b1);
    send_pixel(make_pixel(-32768, 32767, 0, 0, 32767, -32768, 0));
    send_pixel(make_pixel(1500, 2500, 3500, -32768, 1500, 2500, 3500));
    send_pixel(make_pixel(100, 100, 100, 32767, 100 - EDGE_LIMIT - 1, 100, 100));
    send_pixel(make_pixel(100, 100, 100, 0, 100, 100 - EDGE_LIMIT, 100));
    send_pixel(make_pixel(ONE + 1, -1, ONE, 5, -32768, -32768, -32768));
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0));

    // Random phases. The first few hit the register extremes, including
    // sizes below and above the legal range; the rest use small frames so
    // that many frames complete. The final phases run without idling.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin w = 8191; h = 0; scene = 1'b0; end
        1: begin w = 0; h = 8191; scene = 1'b1; end
        2: begin w = MAX_DIM; h = MAX_DIM; scene = 1'b0; end
        3: begin w = 1; h = 2; scene = 1'b1; end
        default: begin
          w = span(MIN_DIM, 9);
          h = span(MIN_DIM, 6);
          scene = $urandom_range(1);
        end
      endcase
      if (ph >= N_PHASES - 2) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = ($urandom_range(2) == 0) ? 0 : span(10, 40);
        stall_pct = ($urandom_range(2) == 0) ? 0 : span(10, 40);
      end
      apply_settings(w, h, scene);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_pixel(random_pixel());
        // Once, the source waits mid-frame for the block to empty.
        if (ph == 5 && i == PHASE_ITEMS / 2) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d pixel items, %0d frames closed, %0d register settings.",
             tracker.results_seen, tracker.pixels_seen, tracker.frames_seen, settings_used);
    $display("Both alpha modes, clamped frame sizes and mid-frame size changes were covered.");
    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
